// File: sv/bb3_pkg.sv
// Shared types, sizes and helper functions for the 3x3 box blur.
package bb3_pkg;

  // Frame limits
  localparam int unsigned MAX_WIDTH  = 128;
  localparam int unsigned MAX_HEIGHT = 128;

  // Counter and dimension widths
  localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned WD_W  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HT_W  = $clog2(MAX_HEIGHT + 1);

  // Configuration port
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 8'd64;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 8'd32;

  // Item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // Arithmetic widths
  localparam int unsigned CH_W        = 8;
  localparam int unsigned COLSUM_W    = 10;  // three channel values
  localparam int unsigned SUM_W       = 12;  // nine channel values
  localparam int unsigned CNT_W       = 4;   // neighbor count 1..9
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;

  // Result queue (power of two depth)
  localparam int unsigned QDEPTH = 8;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned OCC_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic            kind;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            frame_end;
  } out_item_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  // One window column: slot 0 two rows up, slot 1 one row up, slot 2 newest row
  typedef pixel_t [2:0] column_t;

  typedef struct packed {
    logic [COLSUM_W-1:0] red;
    logic [COLSUM_W-1:0] green;
    logic [COLSUM_W-1:0] blue;
  } colsum_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } sum_t;

  // Window cell controls
  typedef struct packed {
    logic       shift;
    logic [2:0] row_mask;
  } cell_ctl_t;

  // Request into the divide stage
  typedef struct packed {
    logic             valid;
    sum_t             sums;
    logic [CNT_W-1:0] cnt;
    logic             last;
  } div_req_t;

  // Register value 0 counts as 1, anything above the limit as the limit
  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v,
                                            input int unsigned maxv);
    int unsigned val;
    val = int'(v);
    if (val == 0) return 1;
    if (val > maxv) return maxv;
    return val;
  endfunction

  // Scaled reciprocals; exact floor for sums below 2**15
  function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] m;
    case (cnt)
      4'd1:    m = 17'd65536;
      4'd2:    m = 17'd32768;
      4'd3:    m = 17'd21846;
      4'd4:    m = 17'd16384;
      4'd6:    m = 17'd10923;
      4'd9:    m = 17'd7282;
      default: m = 17'd65536;
    endcase
    return m;
  endfunction

endpackage

// File: sv/bb3_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bb3_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 128
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/bb3_cell.sv
// One window column cell: holds three pixels, passes them on, sums masked slots.
module bb3_cell import bb3_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  column_t   col_in,
  output column_t   col_out,
  output colsum_t   col_sum
);

  column_t col_r;

  // Take the neighbor's column on every window step
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      col_r <= col_in;
    end
  end

  assign col_out = col_r;

  // Column sum over the rows that lie inside the frame
  always_comb begin
    col_sum = '0;
    for (int s = 0; s < 3; s++) begin
      if (ctl.row_mask[s]) begin
        col_sum.red   = col_sum.red   + COLSUM_W'(col_r[s].red);
        col_sum.green = col_sum.green + COLSUM_W'(col_r[s].green);
        col_sum.blue  = col_sum.blue  + COLSUM_W'(col_r[s].blue);
      end
    end
  end

endmodule

// File: sv/bb3_div.sv
// Floor division of the three channel sums by the neighbor count.
module bb3_div import bb3_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  div_req_t  req,
  output logic      res_valid,
  output out_item_t res
);

  logic [RECIP_W-1:0]       recip;
  logic [SUM_W+RECIP_W-1:0] prod_r;
  logic [SUM_W+RECIP_W-1:0] prod_g;
  logic [SUM_W+RECIP_W-1:0] prod_b;
  logic                     res_valid_r;
  out_item_t                res_r;

  // Multiply by the scaled reciprocal, quotient is the upper part
  assign recip  = recip_of(req.cnt);
  assign prod_r = (SUM_W+RECIP_W)'(req.sums.red)   * (SUM_W+RECIP_W)'(recip);
  assign prod_g = (SUM_W+RECIP_W)'(req.sums.green) * (SUM_W+RECIP_W)'(recip);
  assign prod_b = (SUM_W+RECIP_W)'(req.sums.blue)  * (SUM_W+RECIP_W)'(recip);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    res_r.out_red   <= prod_r[RECIP_SHIFT +: CH_W];
    res_r.out_green <= prod_g[RECIP_SHIFT +: CH_W];
    res_r.out_blue  <= prod_b[RECIP_SHIFT +: CH_W];
    res_r.frame_end <= req.last;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

// File: sv/box_blur_3x3_edge_clipped_top.sv
// Top level of the 3x3 box blur with clipped frame edges.
// The block takes one item per clock and gives at most one result per item. Pixels enter
// in raster order; each result is the floor mean of its 3x3 neighborhood, with neighbors
// outside the frame left out (divisor 1, 2, 3, 4, 6 or 9). Results lag the pixel stream
// by one row plus one pixel (less for frames one pixel wide or one row high); once the
// last pixel is in, that many drain items flush the rest, and the last result of a frame
// carries frame_end. A result leaves after its item has passed through the pipeline:
// store read, window shift, column sums and divide each take one stage, then the result
// queue. The queue holds eight results; input is held off only when eight results are
// accepted and not yet taken. Two 128-entry line stores and a row of three window cells
// hold the rows in flight; they need no clearing after reset. Writing either frame size
// register abandons the frame in progress.
module box_blur_3x3_edge_clipped_top import bb3_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  typedef struct packed {
    logic             emit;
    logic             last;
    logic             fwd;
    logic [COL_W-1:0] addr;
    pixel_t           pix;
    logic [2:0]       colv;
    logic [2:0]       rowv;
    logic [CNT_W-1:0] cnt;
  } s1_t;

  typedef struct packed {
    logic [2:0]       colv;
    logic [2:0]       rowv;
    logic [CNT_W-1:0] cnt;
    logic             last;
  } s2_t;

  // Stream state
  logic [WD_W-1:0]  width_r, width_nxt;
  logic [HT_W-1:0]  height_r, height_nxt;
  logic [COL_W-1:0] in_col_r, in_col_nxt;
  logic [ROW_W-1:0] in_row_r, in_row_nxt;
  logic [COL_W-1:0] out_col_r, out_col_nxt;
  logic [ROW_W-1:0] out_row_r, out_row_nxt;
  logic [COL_W-1:0] vc_r, vc_nxt;
  logic             pending_r, pending_nxt;

  // Input stage decode
  logic            a_acc, a_pix, a_emit, a_shift;
  logic [WD_W-1:0] ic_p1, oc_p1, vc_p1, nc;
  logic [HT_W-1:0] ir_p1, or_p1, nr;
  logic            col_end_in, row_end_in, input_done, nbr_ready, out_last;
  logic            wide, tall;
  logic [2:0]      colv, rowv;
  logic [1:0]      n_col, n_row;

  // Pipeline registers
  logic     s1_valid_r;
  s1_t      s1_r, s1_nxt;
  pixel_t   fwd_mid_r, fwd_up_r;
  logic     s2_valid_r;
  s2_t      s2_r;
  div_req_t s3_r;

  // Line stores and window
  logic [$bits(pixel_t)-1:0] mid_rd, up_rd;
  pixel_t                    mid_q, up_q, b_mid, b_up;
  column_t                   new_col;
  column_t                   cell_in  [3];
  column_t                   cell_out [3];
  colsum_t                   cell_sum [3];
  cell_ctl_t                 cell_ctl [3];

  // Divide and result queue
  logic             res_valid;
  out_item_t        res;
  out_item_t        q_r [QDEPTH];
  logic [QPTR_W-1:0] q_wr_r, q_rd_r;
  logic [OCC_W-1:0] q_cnt_r, occ_r;
  logic             out_xfer;

  // Handshake
  assign in_ready  = (occ_r < OCC_W'(QDEPTH));
  assign a_acc     = in_valid && in_ready;
  assign out_valid = (q_cnt_r != '0);
  assign out_data  = q_r[q_rd_r];
  assign out_xfer  = out_valid && out_ready;

  // Position arithmetic for the accepted item
  assign ic_p1 = WD_W'(in_col_r) + WD_W'(1);
  assign oc_p1 = WD_W'(out_col_r) + WD_W'(1);
  assign vc_p1 = WD_W'(vc_r) + WD_W'(1);
  assign ir_p1 = HT_W'(in_row_r) + HT_W'(1);
  assign or_p1 = HT_W'(out_row_r) + HT_W'(1);

  assign col_end_in = (ic_p1 >= width_r);
  assign row_end_in = (ir_p1 >= height_r);
  assign input_done = col_end_in && row_end_in;

  // Lower right neighbor of the next result, clipped to the frame
  assign nr = (or_p1 < height_r) ? or_p1 : (height_r - HT_W'(1));
  assign nc = (oc_p1 < width_r) ? oc_p1 : (width_r - WD_W'(1));
  assign nbr_ready = (nr < HT_W'(in_row_r)) ||
                     ((nr == HT_W'(in_row_r)) && (nc <= WD_W'(in_col_r)));
  assign out_last  = (or_p1 >= height_r) && (oc_p1 >= width_r);

  assign a_pix   = (in_data.kind == KIND_PIXEL) && !pending_r;
  assign a_emit  = a_pix ? nbr_ready : pending_r;
  assign a_shift = a_pix || pending_r;

  // Neighbor masks in window coordinates; center cell and slot move for thin frames
  assign wide    = (width_r != WD_W'(1));
  assign tall    = (height_r != HT_W'(1));
  assign colv[0] = wide && (out_col_r != '0);
  assign colv[1] = wide;
  assign colv[2] = !wide || (oc_p1 < width_r);
  assign rowv[0] = tall && (out_row_r != '0);
  assign rowv[1] = tall;
  assign rowv[2] = !tall || (or_p1 < height_r);
  assign n_col   = 2'(colv[0]) + 2'(colv[1]) + 2'(colv[2]);
  assign n_row   = 2'(rowv[0]) + 2'(rowv[1]) + 2'(rowv[2]);

  // Stream counters
  always_comb begin
    width_nxt   = width_r;
    height_nxt  = height_r;
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    vc_nxt      = vc_r;
    pending_nxt = pending_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  width_nxt  = WD_W'(clamp_dim(cfg_data, MAX_WIDTH));
        CFG_FRAME_HEIGHT: height_nxt = HT_W'(clamp_dim(cfg_data, MAX_HEIGHT));
        default: ;
      endcase
      if (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT) begin
        in_col_nxt  = '0;
        in_row_nxt  = '0;
        out_col_nxt = '0;
        out_row_nxt = '0;
        vc_nxt      = '0;
        pending_nxt = 1'b0;
      end
    end else if (a_acc) begin
      if (a_pix) begin
        if (col_end_in) begin
          in_col_nxt = '0;
          in_row_nxt = row_end_in ? '0 : ROW_W'(ir_p1);
        end else begin
          in_col_nxt = COL_W'(ic_p1);
        end
        pending_nxt = input_done && !(a_emit && out_last);
      end else if (pending_r) begin
        pending_nxt = !out_last;
      end
      if (a_emit) begin
        if (out_last) begin
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (oc_p1 >= width_r) begin
          out_col_nxt = '0;
          out_row_nxt = ROW_W'(or_p1);
        end else begin
          out_col_nxt = COL_W'(oc_p1);
        end
      end
      if (a_shift) begin
        vc_nxt = ((a_emit && out_last) || (vc_p1 >= width_r)) ? '0 : COL_W'(vc_p1);
      end
    end
  end

  // Store read stage payload
  always_comb begin
    s1_nxt.emit = a_emit;
    s1_nxt.last = out_last;
    s1_nxt.fwd  = s1_valid_r && (s1_r.addr == vc_r);
    s1_nxt.addr = vc_r;
    s1_nxt.pix  = '{red: in_data.red, green: in_data.green, blue: in_data.blue};
    s1_nxt.colv = colv;
    s1_nxt.rowv = rowv;
    s1_nxt.cnt  = CNT_W'(n_col) * CNT_W'(n_row);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= WD_W'(clamp_dim(FRAME_WIDTH_RST, MAX_WIDTH));
      height_r   <= HT_W'(clamp_dim(FRAME_HEIGHT_RST, MAX_HEIGHT));
      in_col_r   <= '0;
      in_row_r   <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      vc_r       <= '0;
      pending_r  <= 1'b0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_r.valid <= 1'b0;
      occ_r      <= '0;
    end else begin
      width_r    <= width_nxt;
      height_r   <= height_nxt;
      in_col_r   <= in_col_nxt;
      in_row_r   <= in_row_nxt;
      out_col_r  <= out_col_nxt;
      out_row_r  <= out_row_nxt;
      vc_r       <= vc_nxt;
      pending_r  <= pending_nxt;
      s1_valid_r <= a_acc && a_shift && !cfg_we;
      s2_valid_r <= s1_valid_r && s1_r.emit;
      s3_r.valid <= s2_valid_r;
      occ_r      <= occ_r + OCC_W'(a_acc && a_emit && !cfg_we) - OCC_W'(out_xfer);
    end
  end

  // Pipeline payload; forwarded store data covers a same-column write by the item still in stage 1
  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    if (s1_nxt.fwd) begin
      fwd_mid_r <= s1_r.pix;
      fwd_up_r  <= b_mid;
    end
    s2_r.colv <= s1_r.colv;
    s2_r.rowv <= s1_r.rowv;
    s2_r.cnt  <= s1_r.cnt;
    s2_r.last <= s1_r.last;
    s3_r.sums.red   <= SUM_W'(cell_sum[0].red) + SUM_W'(cell_sum[1].red)
                     + SUM_W'(cell_sum[2].red);
    s3_r.sums.green <= SUM_W'(cell_sum[0].green) + SUM_W'(cell_sum[1].green)
                     + SUM_W'(cell_sum[2].green);
    s3_r.sums.blue  <= SUM_W'(cell_sum[0].blue) + SUM_W'(cell_sum[1].blue)
                     + SUM_W'(cell_sum[2].blue);
    s3_r.cnt  <= s2_r.cnt;
    s3_r.last <= s2_r.last;
  end

  // Line stores: middle holds the previous row, upper the one before
  bb3_ram #(.WIDTH($bits(pixel_t)), .DEPTH(MAX_WIDTH)) u_mid_store (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_r.addr),
    .wdata (s1_r.pix),
    .raddr (vc_r),
    .rdata (mid_rd)
  );

  bb3_ram #(.WIDTH($bits(pixel_t)), .DEPTH(MAX_WIDTH)) u_up_store (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_r.addr),
    .wdata (b_mid),
    .raddr (vc_r),
    .rdata (up_rd)
  );

  assign mid_q = pixel_t'(mid_rd);
  assign up_q  = pixel_t'(up_rd);
  assign b_mid = s1_r.fwd ? fwd_mid_r : mid_q;
  assign b_up  = s1_r.fwd ? fwd_up_r  : up_q;

  assign new_col[0] = b_up;
  assign new_col[1] = b_mid;
  assign new_col[2] = s1_r.pix;

  // Window: three column cells, newest column enters cell 2
  for (genvar k = 0; k < 3; k++) begin : g_cell
    if (k == 2) begin : g_head
      assign cell_in[k] = new_col;
    end else begin : g_link
      assign cell_in[k] = cell_out[k+1];
    end
    assign cell_ctl[k].shift    = s1_valid_r;
    assign cell_ctl[k].row_mask = s2_r.rowv & {3{s2_r.colv[k]}};

    bb3_cell u_cell (
      .clk     (clk),
      .ctl     (cell_ctl[k]),
      .col_in  (cell_in[k]),
      .col_out (cell_out[k]),
      .col_sum (cell_sum[k])
    );
  end

  // Divide by neighbor count
  bb3_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (s3_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r  <= '0;
      q_rd_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      if (res_valid) begin
        q_wr_r <= q_wr_r + QPTR_W'(1);
      end
      if (out_xfer) begin
        q_rd_r <= q_rd_r + QPTR_W'(1);
      end
      q_cnt_r <= q_cnt_r + OCC_W'(res_valid) - OCC_W'(out_xfer);
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      q_r[q_wr_r] <= res;
    end
  end

  // Queued results never exceed what was accepted, nor the queue depth
  assert property (@(posedge clk) disable iff (!rst_n)
    (q_cnt_r <= occ_r) && (occ_r <= OCC_W'(QDEPTH)))
    else $error("result queue occupancy out of bounds");

  // While a frame drains, the input position is back at the frame start
  assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> (in_col_r == '0) && (in_row_r == '0))
    else $error("input position not reset while draining");

  // All column positions stay inside the configured width
  assert property (@(posedge clk) disable iff (!rst_n)
    (WD_W'(vc_r) < width_r) && (WD_W'(in_col_r) < width_r) &&
    (WD_W'(out_col_r) < width_r))
    else $error("column position beyond frame width");

  // An emitting transfer reaches the divide stage through the s1, s2 and s3 registers
  assert property (@(posedge clk) disable iff (!rst_n)
    (a_acc && a_emit && !cfg_we) |-> ##3 s3_r.valid)
    else $error("emitted item lost in pipeline");

endmodule
